@@ rtl/core/rwpo_pkg.sv @@
// ----------------------------------------------------------------------------
// rwpo_pkg
// Shared types and constants of the ROM word patch and overlay unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rwpo_pkg;

    localparam int NUM_PATCHES   = 4;
    localparam int OVERLAY_WORDS = 32768;
    localparam int NUM_REGS      = 3 * NUM_PATCHES + 1;
    localparam int REG_IDX_W     = $clog2(NUM_REGS);
    localparam int MODE_REG      = 3;

    localparam int ADDR_W        = 22;
    localparam int WORD_W        = 16;
    localparam int ADDR_HI_SHIFT = 8;

    localparam logic [WORD_W-1:0] ADDR_HI_MASK = 16'h3f00;
    localparam logic [WORD_W-1:0] MODE_MAGIC   = 16'hffff;
    localparam logic [7:0]        PRO2_OFFSET  = 8'h78;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SWITCH = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SW_OFF     = 2'd0,
        SW_ON      = 2'd1,
        SW_TRAINER = 2'd2,
        SW_NONE    = 2'd3
    } switch_t;

    typedef enum logic [1:0] {
        BOARD_PLAIN = 2'd0,
        BOARD_PRO1  = 2'd1,
        BOARD_PRO2  = 2'd2,
        BOARD_ALT   = 2'd3
    } board_t;

    function automatic int patch_base(input int k);
        return (k == 0) ? 0 : 3 * k + 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rom_word_patch_overlay_unit.sv @@
// ----------------------------------------------------------------------------
// rom_word_patch_overlay_unit
// ROM patch unit: register bank, latched patches, internal ROM overlay.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  in       | in_valid / in_stall       | op, bus_offset, write_data,
//           |                           | read_word_addr, original_word,
//           |                           | switch_pos, hard_reset
//  out      | out_valid / out_stall     | read_data, patched, internal_rom,
//           |                           | switch_state
//  cfg      | cfg_valid / cfg_ready     | board_type
//
//  The input register feeds one pass of decode, compare and update logic into
//  the result register. One beat per cycle is sustained while out does not
//  stall; the four patch comparators work in parallel.
//  State updates when a beat moves from the input register to the result
//  register. A stalled result holds the input register, which then stalls in.
//  Reset clears the register bank, latched patches and switch, maps the overlay.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_word_patch_overlay_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  board_type,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] bus_offset,
    input  wire logic [15:0] write_data,
    input  wire logic [21:0] read_word_addr,
    input  wire logic [15:0] original_word,
    input  wire logic [1:0]  switch_pos,
    input  wire logic        hard_reset,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      read_data,
    output logic             patched,
    output logic             internal_rom,
    output logic [1:0]       switch_state
);

    localparam int NP = rwpo_pkg::NUM_PATCHES;
    localparam int NR = rwpo_pkg::NUM_REGS;
    localparam int IW = rwpo_pkg::REG_IDX_W;
    localparam int AW = rwpo_pkg::ADDR_W;
    localparam int WW = rwpo_pkg::WORD_W;

    rwpo_pkg::board_t  board_reg;

    logic              s1_valid_reg;
    rwpo_pkg::op_t     s1_op_reg;
    logic [15:0]       s1_offset_reg;
    logic [WW-1:0]     s1_wdata_reg;
    logic [AW-1:0]     s1_raddr_reg;
    logic [WW-1:0]     s1_orig_reg;
    logic [1:0]        s1_pos_reg;
    logic              s1_hard_reg;

    logic [WW-1:0]     regs_reg  [NR];
    logic [WW-1:0]     regs_next [NR];
    logic [AW-1:0]     paddr_reg  [NP];
    logic [AW-1:0]     paddr_next [NP];
    logic [WW-1:0]     pdata_reg  [NP];
    logic [WW-1:0]     pdata_next [NP];
    rwpo_pkg::switch_t sw_reg;
    rwpo_pkg::switch_t sw_next;
    logic              overlay_reg;
    logic              overlay_next;

    logic              out_valid_reg;
    logic [WW-1:0]     rdata_reg;
    logic [WW-1:0]     rdata_next;
    logic              patched_reg;
    logic              patched_next;
    logic              inrom_reg;
    logic              inrom_next;

    logic              in_fire;
    logic              s1_adv;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign patched      = patched_reg;
    assign internal_rom = inrom_reg;
    assign switch_state = sw_reg;

    always_comb
    begin
        logic [14:0]       idx;
        logic [WW-1:0]     mode_val;
        logic              do_latch;
        logic              do_clear;
        logic              patch_en;
        rwpo_pkg::switch_t pos;
        int                b;

        idx      = s1_offset_reg[15:1];
        mode_val = '0;
        do_latch = 1'b0;
        do_clear = 1'b0;
        patch_en = 1'b0;
        pos      = rwpo_pkg::switch_t'(s1_pos_reg);
        b        = 0;

        for (int r = 0; r < NR; r++)
        begin
            regs_next[r] = regs_reg[r];
        end
        for (int k = 0; k < NP; k++)
        begin
            paddr_next[k] = paddr_reg[k];
            pdata_next[k] = pdata_reg[k];
        end
        sw_next      = sw_reg;
        overlay_next = overlay_reg;
        rdata_next   = '0;
        patched_next = 1'b0;
        inrom_next   = 1'b0;

        unique case (s1_op_reg)
            rwpo_pkg::OP_WRITE:
            begin
                if (board_reg == rwpo_pkg::BOARD_PRO2)
                begin
                    if (s1_offset_reg[7:0] == rwpo_pkg::PRO2_OFFSET &&
                        s1_wdata_reg == rwpo_pkg::MODE_MAGIC)
                    begin
                        overlay_next = 1'b0;
                    end
                end
                else if (idx < 15'(NR))
                begin
                    regs_next[idx[IW-1:0]] = s1_wdata_reg;
                    mode_val = regs_next[rwpo_pkg::MODE_REG];
                    if (mode_val == rwpo_pkg::MODE_MAGIC)
                    begin
                        do_latch     = (sw_reg == rwpo_pkg::SW_ON);
                        overlay_next = 1'b0;
                    end
                end
            end
            rwpo_pkg::OP_READ:
            begin
                rdata_next = s1_orig_reg;
                patch_en   = (sw_reg == rwpo_pkg::SW_ON) &&
                             (board_reg != rwpo_pkg::BOARD_PRO2);
                if (overlay_reg && s1_raddr_reg < AW'(rwpo_pkg::OVERLAY_WORDS))
                begin
                    inrom_next = 1'b1;
                end
                else if (patch_en)
                begin
                    for (int k = 0; k < NP; k++)
                    begin
                        if (paddr_reg[k] == s1_raddr_reg)
                        begin
                            rdata_next   = pdata_reg[k];
                            patched_next = 1'b1;
                        end
                    end
                end
            end
            rwpo_pkg::OP_SWITCH:
            begin
                if (pos == rwpo_pkg::SW_TRAINER &&
                    board_reg != rwpo_pkg::BOARD_PRO1 &&
                    board_reg != rwpo_pkg::BOARD_PRO2)
                begin
                    pos = rwpo_pkg::SW_OFF;
                end
                if (pos != rwpo_pkg::SW_NONE)
                begin
                    do_latch = (pos == rwpo_pkg::SW_ON) && (sw_reg != rwpo_pkg::SW_ON);
                    sw_next  = pos;
                end
            end
            rwpo_pkg::OP_RESET:
            begin
                do_clear = s1_hard_reg || (sw_reg == rwpo_pkg::SW_TRAINER);
            end
        endcase

        if (do_latch)
        begin
            for (int k = 0; k < NP; k++)
            begin
                b = rwpo_pkg::patch_base(k);
                pdata_next[k] = regs_next[IW'(b)];
                paddr_next[k] = AW'(regs_next[IW'(b + 1)]) |
                                (AW'(regs_next[IW'(b + 2)] & rwpo_pkg::ADDR_HI_MASK)
                                 << rwpo_pkg::ADDR_HI_SHIFT);
            end
        end

        if (do_clear)
        begin
            for (int r = 0; r < NR; r++)
            begin
                regs_next[r] = '0;
            end
            for (int k = 0; k < NP; k++)
            begin
                paddr_next[k] = '0;
                pdata_next[k] = '0;
            end
            overlay_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg <= rwpo_pkg::BOARD_PLAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            board_reg <= rwpo_pkg::board_t'(board_type);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= rwpo_pkg::op_t'(op);
            s1_offset_reg <= bus_offset;
            s1_wdata_reg  <= write_data;
            s1_raddr_reg  <= read_word_addr;
            s1_orig_reg   <= original_word;
            s1_pos_reg    <= switch_pos;
            s1_hard_reg   <= hard_reset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NR; r++)
            begin
                regs_reg[r] <= '0;
            end
            for (int k = 0; k < NP; k++)
            begin
                paddr_reg[k] <= '0;
                pdata_reg[k] <= '0;
            end
            sw_reg      <= rwpo_pkg::SW_OFF;
            overlay_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            regs_reg    <= regs_next;
            paddr_reg   <= paddr_next;
            pdata_reg   <= pdata_next;
            sw_reg      <= sw_next;
            overlay_reg <= overlay_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rdata_reg   <= rdata_next;
            patched_reg <= patched_next;
            inrom_reg   <= inrom_next;
        end
    end

endmodule

`default_nettype wire
